/* rtl/core/pmat_pkg.sv */
// Shared types, codes and constants for the perspective matrix block.
`timescale 1ns / 1ps
package pmat_pkg;

  localparam logic [1:0] KIND_WR   = 2'd0;
  localparam logic [1:0] KIND_RD   = 2'd1;
  localparam logic [1:0] KIND_PROJ = 2'd2;

  localparam int          CORDIC_STEPS = 30;
  localparam logic [32:0] CORDIC_GAIN  = 33'd652032874;
  localparam logic [32:0] PI_OVER_360  = 33'd9370165;

  localparam logic [1:0] DIV_C  = 2'd0;
  localparam logic [1:0] DIV_CA = 2'd1;
  localparam logic [1:0] DIV_Z1 = 2'd2;
  localparam logic [1:0] DIV_Z2 = 2'd3;

  localparam logic [2:0] PH_COL0  = 3'd0;
  localparam logic [2:0] PH_COL1  = 3'd1;
  localparam logic [2:0] PH_LOADB = 3'd2;
  localparam logic [2:0] PH_Z2    = 3'd3;
  localparam logic [2:0] PH_Z1    = 3'd4;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_ANG  = 12'b000000000010,
    S_NF   = 12'b000000000100,
    S_CORD = 12'b000000001000,
    S_DSET = 12'b000000010000,
    S_DIV  = 12'b000000100000,
    S_URD  = 12'b000001000000,
    S_UCAP = 12'b000010000000,
    S_UWR  = 12'b000100000000,
    S_ORD  = 12'b001000000000,
    S_OCAP = 12'b010000000000,
    S_PUSH = 12'b100000000000
  } state_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 32'h3243F6A8;
      5'd1:  atan_q30 = 32'h1DAC6705;
      5'd2:  atan_q30 = 32'h0FADBAFC;
      5'd3:  atan_q30 = 32'h07F56EA6;
      5'd4:  atan_q30 = 32'h03FEAB76;
      5'd5:  atan_q30 = 32'h01FFD55B;
      5'd6:  atan_q30 = 32'h00FFFAAA;
      5'd7:  atan_q30 = 32'h007FFF55;
      5'd8:  atan_q30 = 32'h003FFFEA;
      5'd9:  atan_q30 = 32'h001FFFFD;
      5'd10: atan_q30 = 32'h000FFFFF;
      5'd11: atan_q30 = 32'h0007FFFF;
      5'd12: atan_q30 = 32'h0003FFFF;
      5'd13: atan_q30 = 32'h0001FFFF;
      5'd14: atan_q30 = 32'h0000FFFF;
      5'd15: atan_q30 = 32'h00007FFF;
      5'd16: atan_q30 = 32'h00003FFF;
      5'd17: atan_q30 = 32'h00001FFF;
      5'd18: atan_q30 = 32'h00000FFF;
      5'd19: atan_q30 = 32'h000007FF;
      5'd20: atan_q30 = 32'h000003FF;
      5'd21: atan_q30 = 32'h000001FF;
      5'd22: atan_q30 = 32'h000000FF;
      5'd23: atan_q30 = 32'h0000007F;
      5'd24: atan_q30 = 32'h0000003F;
      5'd25: atan_q30 = 32'h0000001F;
      5'd26: atan_q30 = 32'h0000000F;
      5'd27: atan_q30 = 32'h00000008;
      5'd28: atan_q30 = 32'h00000004;
      5'd29: atan_q30 = 32'h00000002;
      default: atan_q30 = 32'h00000000;
    endcase
  endfunction

  function automatic logic [1:0] src_col(input logic [2:0] ph);
    case (ph)
      PH_COL0:  src_col = 2'd0;
      PH_COL1:  src_col = 2'd1;
      PH_LOADB: src_col = 2'd3;
      default:  src_col = 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] dst_col(input logic [2:0] ph);
    case (ph)
      PH_COL0: dst_col = 2'd0;
      PH_COL1: dst_col = 2'd1;
      PH_Z2:   dst_col = 2'd3;
      default: dst_col = 2'd2;
    endcase
  endfunction

  function automatic logic [31:0] sat66(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat66 = 32'h7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      sat66 = 32'h80000000;
    end else begin
      sat66 = v[31:0];
    end
  endfunction

  function automatic logic [31:0] sat_div(input logic neg, input logic [63:0] q);
    if (!neg) begin
      sat_div = (q > 64'd2147483647) ? 32'h7FFFFFFF : q[31:0];
    end else begin
      sat_div = (q > 64'h80000000) ? 32'h80000000 : (32'd0 - q[31:0]);
    end
  endfunction

endpackage

/* rtl/core/pmat_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module pmat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/perspective_matrix_apply.sv */
// Perspective projection applied to a stored 4x4 matrix: top level.
// A write goes straight to S_PUSH for its result beat; a read first captures the store word in S_OCAP.
// A projection computes the half-angle and runs a 30-step CORDIC, then does up to four divisions
// on one restoring divider and the row updates before its first beat. Each beat then passes
// S_ORD, S_OCAP and S_PUSH, which holds on an output stall; the input stalls until the last beat.
// Reset returns the store to the identity matrix through per-entry valid bits.
`timescale 1ns / 1ps
module perspective_matrix_apply import pmat_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_elem_index,
  input  logic signed [31:0] in_elem_value,
  input  logic [23:0] in_fov_deg,
  input  logic [30:0] in_aspect_ratio,
  input  logic signed [31:0] in_near_plane,
  input  logic signed [31:0] in_far_plane,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_index,
  output logic signed [31:0] out_value,
  output logic        out_last,
  output logic        out_error
);

  localparam logic signed [31:0] ONE_Q   = 32'sd1 <<< FRAC_BITS;
  localparam logic [63:0]         FOV_LIM = 64'd180 << FRAC_BITS;

  state_t state_r, state_nxt;

  logic        in_acc, out_free;
  logic [23:0] fov_r;
  logic [30:0] aspect_r;
  logic signed [31:0] n_r, f_r;
  logic        bad_proj;

  logic [15:0] valid_r;
  logic        ram_we;
  logic [3:0]  ram_waddr, raddr, raddr_r;
  logic [31:0] ram_wdata, ram_q, rd_data;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic        prod_en;

  logic signed [33:0] x_r, y_r, z_r, dx, dy, atan_x, x_clamp;
  logic [4:0]  it_r;

  logic [1:0]  sel_r;
  logic [63:0] dvd_r, q_fin;
  logic [32:0] rem_r, dvs_r;
  logic [33:0] rem_sh;
  logic        ge, neg_r;
  logic [5:0]  div_cnt_r;
  logic signed [32:0] sum_nf, dif_nf;
  logic [32:0] sum_abs, dif_abs;
  logic [31:0] n_abs, f_abs;
  logic [31:0] div_res;

  logic signed [31:0] c_r, ca_r, z1_r, z2_r, b_r, factor;
  logic [1:0]  row_r;
  logic [2:0]  ph_r;
  logic [31:0] upd_val;
  logic [3:0]  oi_r;

  logic [3:0]  pend_idx_r;
  logic [31:0] pend_val_r;
  logic        pend_last_r, pend_err_r;
  logic        out_valid_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  assign bad_proj = (in_aspect_ratio == 31'd0) || (in_near_plane == in_far_plane) ||
                    (in_fov_deg == 24'd0) || ({40'd0, in_fov_deg} >= FOV_LIM);

  pmat_ram #(.WIDTH(32), .DEPTH(16)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_comb begin
    case (state_r)
      S_IDLE:  raddr = in_elem_index;
      S_URD:   raddr = {src_col(ph_r), row_r};
      S_ORD:   raddr = oi_r;
      default: raddr = raddr_r;
    endcase
  end

  assign rd_data = valid_r[raddr_r] ? ram_q :
                   ((raddr_r[1:0] == raddr_r[3:2]) ? ONE_Q : 32'd0);

  assign upd_val = sat66((prod_r >>> FRAC_BITS) -
                         ((ph_r == PH_Z1) ? 66'(b_r) : 66'sd0));

  assign ram_we    = (in_acc && in_kind == KIND_WR) || (state_r == S_UWR);
  assign ram_waddr = (state_r == S_UWR) ? {dst_col(ph_r), row_r} : in_elem_index;
  assign ram_wdata = (state_r == S_UWR) ? upd_val : in_elem_value;

  always_comb begin
    case (ph_r)
      PH_COL0: factor = ca_r;
      PH_COL1: factor = c_r;
      PH_Z2:   factor = z2_r;
      default: factor = z1_r;
    endcase
  end

  assign n_abs = n_r[31] ? (32'd0 - n_r) : n_r;
  assign f_abs = f_r[31] ? (32'd0 - f_r) : f_r;

  always_comb begin
    prod_en = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_r)
      S_ANG: begin
        prod_en = 1'b1;
        mul_a   = {9'd0, fov_r};
        mul_b   = PI_OVER_360;
      end
      S_NF: begin
        prod_en = 1'b1;
        mul_a   = {1'b0, n_abs};
        mul_b   = {1'b0, f_abs};
      end
      S_UCAP: begin
        prod_en = (ph_r != PH_LOADB);
        mul_a   = 33'(signed'(rd_data));
        mul_b   = 33'(factor);
      end
      default: begin
        prod_en = 1'b0;
      end
    endcase
  end

  assign dx      = y_r >>> it_r;
  assign dy      = x_r >>> it_r;
  assign atan_x  = {2'b00, atan_q30(it_r)};
  assign x_clamp = x_r[33] ? 34'sd0 : x_r;

  assign sum_nf  = 33'(n_r) + 33'(f_r);
  assign dif_nf  = 33'(n_r) - 33'(f_r);
  assign sum_abs = sum_nf[32] ? (33'd0 - sum_nf) : sum_nf;
  assign dif_abs = dif_nf[32] ? (33'd0 - dif_nf) : dif_nf;

  assign rem_sh  = {rem_r, dvd_r[63]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign q_fin   = {dvd_r[62:0], ge};
  assign div_res = sat_div(neg_r, q_fin);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_WR:   state_nxt = S_PUSH;
            KIND_RD:   state_nxt = S_OCAP;
            KIND_PROJ: state_nxt = bad_proj ? S_PUSH : S_ANG;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ANG:  state_nxt = S_NF;
      S_NF:   state_nxt = S_CORD;
      S_CORD: state_nxt = (it_r == 5'(CORDIC_STEPS - 1)) ? S_DSET : S_CORD;
      S_DSET: state_nxt = (sel_r == DIV_C && y_r <= 34'sd0) ? S_DSET : S_DIV;
      S_DIV: begin
        if (div_cnt_r == 6'd63) begin
          state_nxt = (sel_r == DIV_Z2) ? S_URD : S_DSET;
        end
      end
      S_URD:  state_nxt = S_UCAP;
      S_UCAP: state_nxt = (ph_r == PH_LOADB) ? S_URD : S_UWR;
      S_UWR:  state_nxt = (ph_r == PH_Z1 && row_r == 2'd3) ? S_ORD : S_URD;
      S_ORD:  state_nxt = S_OCAP;
      S_OCAP: state_nxt = S_PUSH;
      S_PUSH: begin
        if (out_free) begin
          state_nxt = pend_last_r ? S_IDLE : S_ORD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (state_r == S_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_r <= raddr;
    if (prod_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (state_r)
      S_IDLE: begin
        fov_r    <= in_fov_deg;
        aspect_r <= in_aspect_ratio;
        n_r      <= in_near_plane;
        f_r      <= in_far_plane;
        oi_r     <= 4'hF;
        if (in_kind == KIND_WR) begin
          pend_idx_r  <= in_elem_index;
          pend_val_r  <= in_elem_value;
          pend_last_r <= 1'b1;
          pend_err_r  <= 1'b0;
        end else begin
          pend_idx_r  <= 4'd0;
          pend_val_r  <= 32'd0;
          pend_last_r <= 1'b1;
          pend_err_r  <= 1'b1;
        end
      end
      S_NF: begin
        z_r  <= prod_r[FRAC_BITS+33:FRAC_BITS];
        x_r  <= 34'(CORDIC_GAIN);
        y_r  <= 34'sd0;
        it_r <= 5'd0;
      end
      S_CORD: begin
        if (!z_r[33]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_x;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_x;
        end
        it_r  <= it_r + 5'd1;
        sel_r <= DIV_C;
      end
      S_DSET: begin
        rem_r     <= 33'd0;
        div_cnt_r <= 6'd0;
        case (sel_r)
          DIV_C: begin
            if (y_r <= 34'sd0) begin
              c_r   <= 32'sh7FFFFFFF;
              sel_r <= DIV_CA;
            end
            dvd_r <= 64'(unsigned'(x_clamp)) << FRAC_BITS;
            dvs_r <= y_r[32:0];
            neg_r <= 1'b0;
          end
          DIV_CA: begin
            dvd_r <= 64'(unsigned'(c_r)) << FRAC_BITS;
            dvs_r <= {2'b00, aspect_r};
            neg_r <= 1'b0;
          end
          DIV_Z1: begin
            dvd_r <= 64'(sum_abs) << FRAC_BITS;
            dvs_r <= dif_abs;
            neg_r <= sum_nf[32] ^ dif_nf[32];
          end
          default: begin
            dvd_r <= {prod_r[62:0], 1'b0};
            dvs_r <= dif_abs;
            neg_r <= (n_r[31] ^ f_r[31]) ^ dif_nf[32];
          end
        endcase
      end
      S_DIV: begin
        rem_r     <= ge ? 33'(rem_sh - {1'b0, dvs_r}) : rem_sh[32:0];
        dvd_r     <= q_fin;
        div_cnt_r <= div_cnt_r + 6'd1;
        if (div_cnt_r == 6'd63) begin
          case (sel_r)
            DIV_C:   c_r  <= div_res;
            DIV_CA:  ca_r <= div_res;
            DIV_Z1:  z1_r <= div_res;
            default: z2_r <= div_res;
          endcase
          sel_r <= sel_r + 2'd1;
          row_r <= 2'd0;
          ph_r  <= PH_COL0;
        end
      end
      S_UCAP: begin
        if (ph_r == PH_LOADB) begin
          b_r  <= rd_data;
          ph_r <= PH_Z2;
        end
      end
      S_UWR: begin
        oi_r <= 4'd0;
        if (ph_r == PH_Z1) begin
          ph_r  <= PH_COL0;
          row_r <= row_r + 2'd1;
        end else begin
          ph_r <= ph_r + 3'd1;
        end
      end
      S_OCAP: begin
        pend_idx_r  <= raddr_r;
        pend_val_r  <= rd_data;
        pend_last_r <= (oi_r == 4'hF);
        pend_err_r  <= 1'b0;
      end
      S_PUSH: begin
        if (out_free) begin
          out_index <= pend_idx_r;
          out_value <= pend_val_r;
          out_last  <= pend_last_r;
          out_error <= pend_err_r;
          oi_r      <= oi_r + 4'd1;
        end
      end
      default: begin
        oi_r <= oi_r;
      end
    endcase
  end

  a_store_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_UWR))
    else $error("store written outside a write beat or an update pass");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_last && out_value == 32'sd0))
    else $error("error result is not a single zero beat");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == 6'd63) |=> (state_r == S_DSET || state_r == S_URD))
    else $error("divider finished without moving on");

endmodule

/* tb/sv/tb_perspective_matrix_apply.sv */
// Self-checking testbench for the perspective projection matrix block.
`timescale 1ns / 1ps
module tb_perspective_matrix_apply import pmat_pkg::*;;

  class matrix_scoreboard;
    logic signed [63:0] elem [16];
    logic [3:0]  exp_index [$];
    logic [31:0] exp_value [$];
    logic        exp_last [$];
    logic        exp_error [$];
    int          fails;
    int          matched;

    function new();
      fails = 0;
      matched = 0;
      for (int i = 0; i < 16; i++) begin
        elem[i] = 0;
      end
      elem[0] = 64'sd65536;
      elem[5] = 64'sd65536;
      elem[10] = 64'sd65536;
      elem[15] = 64'sd65536;
    endfunction

    function void push(logic [3:0] idx, logic [31:0] val, logic lst, logic err);
      exp_index.push_back(idx);
      exp_value.push_back(val);
      exp_last.push_back(lst);
      exp_error.push_back(err);
    endfunction

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v);
      return v >>> 16;
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function automatic logic signed [63:0] half_cot(logic [23:0] fov);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic signed [63:0] a;
      x = 64'sd652032874;
      y = 0;
      z = $signed((64'(fov) * 64'd9370165) >> 16);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        a = $signed({32'd0, atan_q30(5'(i))});
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - a;
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + a;
        end
      end
      if (x < 0) begin
        x = 0;
      end
      if (y <= 0) begin
        return 64'sd2147483647;
      end
      return clamp32((x * 64'sd65536) / y);
    endfunction

    function void note_input(logic [1:0] kind, logic [3:0] idx, logic [31:0] val,
                             logic [23:0] fov, logic [30:0] asp,
                             logic [31:0] near_v, logic [31:0] far_v);
      logic signed [63:0] n, f, c, ca, z1, z2, d, a, b;
      logic [63:0] mag, dmag;
      logic neg;
      if (kind == KIND_WR) begin
        elem[idx] = $signed(val);
        push(idx, val, 1'b1, 1'b0);
      end else if (kind == KIND_RD) begin
        push(idx, elem[idx][31:0], 1'b1, 1'b0);
      end else if (kind == KIND_PROJ) begin
        n = $signed(near_v);
        f = $signed(far_v);
        if (asp == 0 || n == f || fov == 0 || fov >= (24'd180 << 16)) begin
          push(4'd0, 32'd0, 1'b1, 1'b1);
          return;
        end
        c = half_cot(fov);
        ca = clamp32((c * 64'sd65536) / $signed({33'd0, asp}));
        d = n - f;
        z1 = clamp32(((n + f) * 64'sd65536) / d);
        mag = 64'd2 * 64'(n < 0 ? -n : n) * 64'(f < 0 ? -f : f);
        dmag = 64'(d < 0 ? -d : d);
        mag = mag / dmag;
        neg = ((n < 0) != (f < 0)) != (d < 0);
        if (mag > 64'd2147483648) begin
          mag = 64'd2147483648;
        end
        z2 = neg ? -$signed(mag) : clamp32($signed(mag));
        if (n == 0 || f == 0) begin
          z2 = 0;
        end
        for (int i = 0; i < 4; i++) begin
          a = elem[8 + i];
          b = elem[12 + i];
          elem[i] = clamp32(floor_shift(elem[i] * ca));
          elem[4 + i] = clamp32(floor_shift(elem[4 + i] * c));
          elem[8 + i] = clamp32(floor_shift(a * z1) - b);
          elem[12 + i] = clamp32(floor_shift(a * z2));
        end
        for (int i = 0; i < 16; i++) begin
          push(4'(i), elem[i][31:0], i == 15, 1'b0);
        end
      end
    endfunction

    function void check_result(logic [3:0] idx, logic [31:0] val, logic lst, logic err);
      if (exp_index.size() == 0) begin
        $error("unexpected beat: index %0d value %h", idx, val);
        fails++;
        return;
      end
      if (exp_index[0] !== idx) begin
        $error("out_index: expected %0d, got %0d", exp_index[0], idx);
        fails++;
      end
      if (exp_value[0] !== val) begin
        $error("out_value: expected %h, got %h", exp_value[0], val);
        fails++;
      end
      if (exp_last[0] !== lst) begin
        $error("out_last: expected %0b, got %0b", exp_last[0], lst);
        fails++;
      end
      if (exp_error[0] !== err) begin
        $error("out_error: expected %0b, got %0b", exp_error[0], err);
        fails++;
      end
      void'(exp_index.pop_front());
      void'(exp_value.pop_front());
      void'(exp_last.pop_front());
      void'(exp_error.pop_front());
      matched++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [3:0]  in_elem_index;
  logic signed [31:0] in_elem_value;
  logic [23:0] in_fov_deg;
  logic [30:0] in_aspect_ratio;
  logic signed [31:0] in_near_plane;
  logic signed [31:0] in_far_plane;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_index;
  logic signed [31:0] out_value;
  logic        out_last;
  logic        out_error;

  matrix_scoreboard board;
  int  sent;
  int  proj_count;
  int  err_count;
  bit  hold_off;

  perspective_matrix_apply dut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic send_beat(logic [1:0] kind, logic [3:0] idx, logic [31:0] val,
                           logic [23:0] fov, logic [30:0] asp,
                           logic [31:0] near_v, logic [31:0] far_v, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_elem_index <= idx;
    in_elem_value <= val;
    in_fov_deg <= fov;
    in_aspect_ratio <= asp;
    in_near_plane <= near_v;
    in_far_plane <= far_v;
    do begin
      @(posedge clk);
    end while (in_stall);
    board.note_input(kind, idx, val, fov, asp, near_v, far_v);
    if (kind == KIND_PROJ) begin
      proj_count++;
    end
    sent++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_random(int gap);
    logic [1:0] kind;
    logic [23:0] fov;
    logic [30:0] asp;
    logic [31:0] n, f;
    int pick;
    pick = $urandom_range(0, 9);
    kind = pick < 4 ? KIND_WR : (pick < 7 ? KIND_RD : (pick < 9 ? KIND_PROJ : 2'd3));
    fov = 24'($urandom_range(1, (180 << 16) - 1));
    asp = 31'($urandom_range(1 << 14, 4 << 16));
    n = $urandom_range(1 << 12, 10 << 16);
    f = n + $urandom_range(1, 1000 << 16);
    if ($urandom_range(0, 7) == 0) begin
      fov = 24'($urandom);
      asp = 31'($urandom);
      n = $urandom;
      f = $urandom;
    end
    if ($urandom_range(0, 9) == 0) begin
      n = -n;
    end
    send_beat(kind, 4'($urandom), $urandom_range(0, 3) == 0 ? $urandom :
              $urandom_range(0, 4 << 16) - (2 << 16), fov, asp, n, f, gap);
  endtask

  task automatic wait_drained();
    while (board.exp_index.size() != 0) begin
      @(posedge clk);
    end
    repeat (400) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      board.check_result(out_index, out_value, out_last, out_error);
      if (out_error) begin
        err_count++;
      end
    end
  end

  initial begin
    int gap;
    out_stall <= 1'b0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(0, 18);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    board = new();
    sent = 0;
    proj_count = 0;
    err_count = 0;
    hold_off = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_WR;
    in_elem_index <= '0;
    in_elem_value <= '0;
    in_fov_deg <= '0;
    in_aspect_ratio <= '0;
    in_near_plane <= '0;
    in_far_plane <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(KIND_RD, 4'd0, 0, 0, 0, 0, 0, 0);
    send_beat(KIND_RD, 4'd15, 0, 0, 0, 0, 0, 0);
    send_beat(KIND_PROJ, 0, 0, 24'd90 << 16, 31'd1 << 16, 32'd1 << 16, 32'd100 << 16, 0);
    send_beat(KIND_WR, 4'd3, 32'h7FFFFFFF, 0, 0, 0, 0, 1);
    send_beat(KIND_WR, 4'd8, 32'h80000000, 0, 0, 0, 0, 0);
    send_beat(KIND_WR, 4'd12, 32'hFFFFFFFF, 0, 0, 0, 0, 0);
    send_beat(KIND_PROJ, 4'hF, 32'hFFFFFFFF, 24'h000001, 31'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 2);
    send_beat(KIND_PROJ, 0, 0, (24'd180 << 16) - 24'd1, 31'd1, 32'h7FFFFFFF,
              32'h80000000, 0);
    send_beat(KIND_PROJ, 0, 0, 24'd0, 31'd1 << 16, 32'd1, 32'd2, 0);
    send_beat(KIND_PROJ, 0, 0, 24'd180 << 16, 31'd1 << 16, 32'd1, 32'd2, 0);
    send_beat(KIND_PROJ, 0, 0, 24'hFFFFFF, 31'd1 << 16, 32'd1, 32'd2, 0);
    send_beat(KIND_PROJ, 0, 0, 24'd60 << 16, 31'd0, 32'd1, 32'd2, 0);
    send_beat(KIND_PROJ, 0, 0, 24'd60 << 16, 31'd1 << 16, 32'd5, 32'd5, 0);
    send_beat(KIND_PROJ, 0, 0, 24'd60 << 16, 31'd2 << 16, 32'd0, 32'd50 << 16, 0);
    send_beat(KIND_PROJ, 0, 0, 24'd45 << 16, 31'd1 << 16, -(32'd2 << 16), 32'd3 << 16, 0);
    send_beat(2'd3, 4'd7, 32'h12345678, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) begin
      send_beat(KIND_RD, 4'(i), 0, 0, 0, 0, 0, 0);
    end

    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 6; i++) begin
          send_random(0);
        end
        idle_input();
      end
    join
    wait_drained();

    for (int i = 0; i < 70; i++) begin
      send_random($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18));
      if (i == 35) begin
        idle_input();
        wait_drained();
      end
    end
    idle_input();
    wait_drained();

    $display("Sent %0d items, %0d projections, checked %0d result beats (%0d errors).",
             sent, proj_count, board.matched, err_count);
    if (board.fails == 0 && board.exp_index.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
